[design/dls_pkg.sv]
// ----------------------------------------------------------------------------
// dls_pkg
// Types, codes and defaults shared by the delta list task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package dls_pkg;

  localparam int DEFAULT_MAX_TASKS = 16;
  localparam int TASK_W            = 8;
  localparam int DELTA_W           = 16;
  localparam int PEND_W            = 5;

  // Command codes
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_ADD      = 2'd1;
  localparam logic [1:0] CMD_DISPATCH = 2'd2;

  // Status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOREADY = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [TASK_W-1:0]  task_id;
    logic [DELTA_W-1:0] delay_ticks;
    logic [DELTA_W-1:0] period_ticks;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              run_valid;
    logic [TASK_W-1:0] run_task_id;
    logic [PEND_W-1:0] pending_count;
  } rsp_item_t;

  // One list entry as stored in the slot memory
  typedef struct packed {
    logic [TASK_W-1:0]  tag;
    logic [DELTA_W-1:0] delta;
    logic [DELTA_W-1:0] period;
  } slot_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_WR,
    S_INS_START,
    S_WALK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_POP_HEAD,
    S_POP_RD,
    S_POP_WR,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

[design/dls_ram.sv]
// ----------------------------------------------------------------------------
// dls_ram
// Slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dls_ram
  import dls_pkg::*;
#(
  parameter int DEPTH = DEFAULT_MAX_TASKS,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire slot_t            wdata,
  input  wire logic             re,
  input  wire logic [IDX_W-1:0] raddr,
  output slot_t                 rdata
);

  slot_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/dls_alu.sv]
// ----------------------------------------------------------------------------
// dls_alu
// Shared compare and subtract unit: a >= b and the distance |a - b|.
// ----------------------------------------------------------------------------
`default_nettype none

module dls_alu
  import dls_pkg::*;
(
  input  wire logic [DELTA_W-1:0] a,
  input  wire logic [DELTA_W-1:0] b,
  output logic                    ge,
  output logic [DELTA_W-1:0]      diff
);

  // Compare once, subtract the smaller operand from the larger
  always_comb begin
    ge   = (a >= b);
    diff = ge ? (a - b) : (b - a);
  end

endmodule

`default_nettype wire

[design/dls_seq.sv]
// ----------------------------------------------------------------------------
// dls_seq
// Sequencer: walks, shifts and updates the delta list one slot at a time
// through the slot memory, and holds the result item register.
// ----------------------------------------------------------------------------
`default_nettype none

module dls_seq
  import dls_pkg::*;
#(
  parameter int MAX_TASKS = DEFAULT_MAX_TASKS,
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
  localparam int CNT_W = $clog2(MAX_TASKS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  output logic                  cmd_ready,
  input  wire cmd_item_t        cmd_item,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output rsp_item_t             rsp_item,
  output logic                  ram_we,
  output logic [IDX_W-1:0]      ram_waddr,
  output slot_t                 ram_wdata,
  output logic                  ram_re,
  output logic [IDX_W-1:0]      ram_raddr,
  input  wire slot_t            ram_rdata
);

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_TASKS);
  localparam logic [CNT_W-1:0] ONE        = CNT_W'(1);

  // Control registers
  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             head_ready, head_ready_next;
  logic             rsp_valid_next;

  // Working registers
  logic [CNT_W-1:0]   k, k_next;
  logic [CNT_W-1:0]   pos, pos_next;
  logic [DELTA_W-1:0] rest, rest_next;
  logic [TASK_W-1:0]  ins_task, ins_task_next;
  logic [DELTA_W-1:0] ins_period, ins_period_next;
  logic               reinsert, reinsert_next;
  logic [1:0]         status, status_next;
  logic               run_valid, run_valid_next;
  logic [TASK_W-1:0]  run_tag, run_tag_next;
  rsp_item_t          rsp_item_next;

  // Shared unit
  logic [DELTA_W-1:0] alu_a, alu_b, alu_diff;
  logic               alu_ge;

  logic [CNT_W-1:0] k_inc, k_dec;

  dls_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .ge   (alu_ge),
    .diff (alu_diff)
  );

  assign k_inc     = k + ONE;
  assign k_dec     = k - ONE;
  assign cmd_ready = (state == S_IDLE);

  // Next state, memory controls and working register updates
  always_comb begin
    state_next      = state;
    count_next      = count;
    head_ready_next = head_ready;
    k_next          = k;
    pos_next        = pos;
    rest_next       = rest;
    ins_task_next   = ins_task;
    ins_period_next = ins_period;
    reinsert_next   = reinsert;
    status_next     = status;
    run_valid_next  = run_valid;
    run_tag_next    = run_tag;
    rsp_item_next   = rsp_item;
    rsp_valid_next  = rsp_valid;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = ram_rdata;
    ram_re          = 1'b0;
    ram_raddr       = '0;
    alu_a           = rest;
    alu_b           = ram_rdata.delta;

    // Drop the result once taken
    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          status_next    = ST_DONE;
          run_valid_next = 1'b0;
          run_tag_next   = '0;
          unique case (cmd_item.cmd)
            CMD_TICK: begin
              if (count != '0) begin
                ram_re     = 1'b1;
                state_next = S_TICK_WR;
              end else begin
                state_next = S_DONE;
              end
            end
            CMD_ADD: begin
              if (count == FULL_COUNT) begin
                status_next = ST_FULL;
                state_next  = S_DONE;
              end else begin
                ins_task_next   = cmd_item.task_id;
                rest_next       = cmd_item.delay_ticks;
                ins_period_next = cmd_item.period_ticks;
                state_next      = S_INS_START;
              end
            end
            CMD_DISPATCH: begin
              if (count != '0 && head_ready) begin
                ram_re     = 1'b1;
                state_next = S_POP_HEAD;
              end else begin
                status_next = ST_NOREADY;
                state_next  = S_DONE;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end

      // Count down the head, or mark it ready at zero
      S_TICK_WR: begin
        alu_a = ram_rdata.delta;
        alu_b = DELTA_W'(1);
        if (ram_rdata.delta == '0) begin
          head_ready_next = 1'b1;
        end else begin
          ram_we          = 1'b1;
          ram_wdata.delta = alu_diff;
        end
        state_next = S_DONE;
      end

      S_INS_START: begin
        k_next   = '0;
        pos_next = count;
        if (count == '0) begin
          state_next = S_INS_WR;
        end else begin
          ram_re     = 1'b1;
          state_next = S_WALK;
        end
      end

      // Pass entries due no later than the new one, else shorten this one
      S_WALK: begin
        if (alu_ge) begin
          rest_next = alu_diff;
          k_next    = k_inc;
          if (k_inc == count) begin
            pos_next   = count;
            state_next = S_INS_WR;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = k_inc[IDX_W-1:0];
          end
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = k[IDX_W-1:0];
          ram_wdata.delta = alu_diff;
          pos_next        = k;
          k_next          = count;
          state_next      = S_SHIFT_RD;
        end
      end

      // Open a gap at pos, moving entries up from the tail
      S_SHIFT_RD: begin
        if (k == pos) begin
          state_next = S_INS_WR;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = k_dec[IDX_W-1:0];
          state_next = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = k[IDX_W-1:0];
        k_next     = k_dec;
        state_next = S_SHIFT_RD;
      end

      S_INS_WR: begin
        ram_we           = 1'b1;
        ram_waddr        = pos[IDX_W-1:0];
        ram_wdata.tag    = ins_task;
        ram_wdata.delta  = rest;
        ram_wdata.period = ins_period;
        count_next       = count + ONE;
        state_next       = S_DONE;
      end

      // Hand out the head and keep it for a periodic re-insert
      S_POP_HEAD: begin
        run_valid_next  = 1'b1;
        run_tag_next    = ram_rdata.tag;
        ins_task_next   = ram_rdata.tag;
        rest_next       = ram_rdata.period;
        ins_period_next = ram_rdata.period;
        reinsert_next   = (ram_rdata.period != '0);
        head_ready_next = 1'b0;
        k_next          = '0;
        state_next      = S_POP_RD;
      end

      // Close the gap at the head, moving entries down
      S_POP_RD: begin
        if (k_inc < count) begin
          ram_re     = 1'b1;
          ram_raddr  = k_inc[IDX_W-1:0];
          state_next = S_POP_WR;
        end else begin
          count_next = count - ONE;
          state_next = reinsert ? S_INS_START : S_DONE;
        end
      end

      S_POP_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = k[IDX_W-1:0];
        k_next     = k_inc;
        state_next = S_POP_RD;
      end

      // Load the result register once it is free
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next              = 1'b1;
          rsp_item_next.status        = status;
          rsp_item_next.run_valid     = run_valid;
          rsp_item_next.run_task_id   = run_tag;
          rsp_item_next.pending_count = PEND_W'(count);
          state_next                  = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      head_ready <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      head_ready <= head_ready_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    k          <= k_next;
    pos        <= pos_next;
    rest       <= rest_next;
    ins_task   <= ins_task_next;
    ins_period <= ins_period_next;
    reinsert   <= reinsert_next;
    status     <= status_next;
    run_valid  <= run_valid_next;
    run_tag    <= run_tag_next;
    rsp_item   <= rsp_item_next;
  end

  // The list never holds more than its capacity
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above capacity");

  // Only a non-empty list can have a ready head
  a_ready_nonempty: assert property (@(posedge clk) disable iff (rst)
    head_ready |-> count != '0)
    else $error("head ready on empty list");

  // No slot is written while waiting for a command
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !ram_we)
    else $error("slot write while idle");

  // A handed-out task always comes with a done status
  a_run_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.run_valid |-> rsp_item.status == ST_DONE)
    else $error("run task with failing status");

  // The count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    count != $past(count) |-> (count == $past(count) + ONE) ||
                              (count == $past(count) - ONE))
    else $error("entry count jumped");

endmodule

`default_nettype wire

[design/delta_list_task_scheduler_top.sv]
// Tick reads the head and writes it back one lower, or marks it ready at zero; add walks
//   past the entries due no later than the new one, then shifts each later entry up by one slot.
// Dispatch pops the head and moves the rest down; a periodic task is then re-inserted as an add.
// One item at a time: the slot memory (one read, one write port) and shared compare/subtract set the pace.
// A finished result waits in an output register while the next item is accepted.
// Reset (rst, synchronous): list empty, head not ready; slot contents are not cleared.
// ----------------------------------------------------------------------------
// delta_list_task_scheduler_top
// Delta-queue task scheduler: tick, add and dispatch over a time-ordered list.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_list_task_scheduler_top
  import dls_pkg::*;
#(
  parameter int MAX_TASKS = DEFAULT_MAX_TASKS
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_ready,
  input  wire cmd_item_t cmd_item,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output rsp_item_t      rsp_item
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  slot_t            ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  slot_t            ram_rdata;

  // Sequencer
  dls_seq #(
    .MAX_TASKS (MAX_TASKS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_item  (cmd_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Slot memory
  dls_ram #(
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

[tb/delta_list_task_scheduler_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delta_list_task_scheduler_top_test
// Self-checking bench for the delta list scheduler. A shadow list model
// predicts every response from the accepted commands. Stimulus is a short
// directed walk through the corner cases, then random rounds that fill and
// drain the list. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------

module delta_list_task_scheduler_top_test;
  import dls_pkg::*;

  localparam int MAX_TASKS    = DEFAULT_MAX_TASKS;
  localparam int RANDOM_ITEMS = 1125;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 4 * MAX_TASKS + 20;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_CYCLES  = 400;
  localparam int PRINT_CAP    = 100;

  // The command code the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_CHOP} rx_mode_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_ready;
  cmd_item_t cmd_item = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp_item;

  delta_list_task_scheduler_top #(
    .MAX_TASKS(MAX_TASKS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_item (cmd_item),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_item (rsp_item)
  );

  always #1 clk = ~clk;

  // Shadow list and bookkeeping
  slot_t     sched_slots [MAX_TASKS];
  int        sched_count = 0;
  bit        sched_ready = 1'b0;
  cmd_item_t cmd_pending_q[$];
  rsp_item_t rsp_expect_q[$];

  int items_accepted   = 0;
  int mismatches       = 0;
  int runs_handed      = 0;
  int adds_refused     = 0;
  int empty_dispatches = 0;
  int peak_count       = 0;
  int cycle_count      = 0;
  int large_budget     = 3;
  int periodic_budget  = 5;
  int rx_hold_left     = 0;
  bit rx_hold_done     = 1'b0;

  // Insert after every entry due no later than the new one; false when full
  function automatic bit list_insert(input logic [TASK_W-1:0] tag,
                                     input logic [DELTA_W-1:0] delay,
                                     input logic [DELTA_W-1:0] period);
    logic [DELTA_W-1:0] rest;
    int                 pos;
    bit                 found;
    if (sched_count >= MAX_TASKS) return 1'b0;
    rest  = delay;
    pos   = sched_count;
    found = 1'b0;
    for (int k = 0; k < sched_count; k++) begin
      if (!found) begin
        if (rest >= sched_slots[k].delta) begin
          rest = rest - sched_slots[k].delta;
        end else begin
          sched_slots[k].delta = sched_slots[k].delta - rest;
          pos   = k;
          found = 1'b1;
        end
      end
    end
    for (int k = sched_count; k > pos; k--) begin
      sched_slots[k] = sched_slots[k-1];
    end
    sched_slots[pos] = '{tag: tag, delta: rest, period: period};
    sched_count++;
    return 1'b1;
  endfunction

  // Advance the shadow list by one command and return its response
  function automatic rsp_item_t sched_apply(input cmd_item_t c);
    rsp_item_t r;
    slot_t     head;
    r = '0;
    case (c.cmd)
      CMD_TICK: begin
        if (sched_count != 0) begin
          if (sched_slots[0].delta == 0) sched_ready = 1'b1;
          else sched_slots[0].delta = sched_slots[0].delta - 1'b1;
        end
      end
      CMD_ADD: begin
        if (!list_insert(c.task_id, c.delay_ticks, c.period_ticks)) begin
          r.status = ST_FULL;
          adds_refused++;
        end
      end
      CMD_DISPATCH: begin
        if (sched_count != 0 && sched_ready) begin
          head          = sched_slots[0];
          r.run_valid   = 1'b1;
          r.run_task_id = head.tag;
          for (int k = 0; k + 1 < sched_count; k++) begin
            sched_slots[k] = sched_slots[k+1];
          end
          sched_count--;
          sched_ready = 1'b0;
          runs_handed++;
          if (head.period != 0) void'(list_insert(head.tag, head.period, head.period));
        end else begin
          r.status = ST_NOREADY;
          empty_dispatches++;
        end
      end
      default: begin
      end
    endcase
    r.pending_count = PEND_W'(sched_count);
    if (sched_count > peak_count) peak_count = sched_count;
    return r;
  endfunction

  task automatic push_cmd(input logic [1:0] cmd, input logic [TASK_W-1:0] tag,
                          input logic [DELTA_W-1:0] delay,
                          input logic [DELTA_W-1:0] period);
    cmd_pending_q.push_back('{cmd: cmd, task_id: tag, delay_ticks: delay,
                              period_ticks: period});
  endtask

  // Random command weighted by the round's mix; ignored fields stay random
  task automatic queue_random_item(input mix_t mix);
    int                 pick;
    int                 add_cut;
    int                 tick_cut;
    int                 disp_cut;
    logic [DELTA_W-1:0] delay;
    logic [DELTA_W-1:0] period;
    pick = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        tick_cut = 20; add_cut = 80; disp_cut = 95;
      end
      MIX_DRAIN: begin
        tick_cut = 50; add_cut = 55; disp_cut = 97;
      end
      default: begin
        tick_cut = 40; add_cut = 65; disp_cut = 95;
      end
    endcase
    delay  = $urandom;
    period = $urandom;
    if (pick < tick_cut) begin
      push_cmd(CMD_TICK, $urandom, delay, period);
    end else if (pick < add_cut) begin
      // Keep far-off and periodic tasks few: neither ever leaves the list
      if (large_budget != 0 && $urandom_range(0, 99) < 3) begin
        large_budget--;
      end else if ($urandom_range(0, 1) == 0) begin
        delay = $urandom_range(0, 3);
      end else begin
        delay = $urandom_range(0, 12);
      end
      if (periodic_budget != 0 && $urandom_range(0, 99) < 8) begin
        periodic_budget--;
        period = $urandom_range(1, 15);
      end else begin
        period = '0;
      end
      push_cmd(CMD_ADD, $urandom, delay, period);
    end else if (pick < disp_cut) begin
      push_cmd(CMD_DISPATCH, $urandom, delay, period);
    end else begin
      push_cmd(CMD_UNUSED, $urandom, delay, period);
    end
  endtask

  // Hold until every queued command is accepted and answered
  task automatic wait_idle();
    while (cmd_pending_q.size() != 0 || cmd_valid || rsp_expect_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      // Stop printing after the first hundred to keep the log short
      if (mismatches <= PRINT_CAP) begin
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      end
    end
  endtask

  // Command driver: bursts of random length with random gaps between them
  int burst_left = 0;
  int gap_left   = 0;
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        rsp_expect_q.push_back(sched_apply(cmd_item));
        items_accepted++;
      end
      if (!cmd_valid || cmd_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          cmd_valid <= 1'b0;
        end else if (cmd_pending_q.size() != 0) begin
          cmd_item  <= cmd_pending_q.pop_front();
          cmd_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once, while commands are still waiting
  always @(posedge clk) begin
    if (rst) begin
      rx_hold_left <= 0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (!rx_hold_done && items_accepted >= HOLD_AT &&
                 cmd_pending_q.size() > 16) begin
      rx_hold_left <= HOLD_CYCLES;
      rx_hold_done <= 1'b1;
    end
  end

  // Response ready: switch stall pattern every so often
  rx_mode_t rx_mode      = RX_OPEN;
  int       rx_mode_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 150);
      end else begin
        rx_mode_left--;
      end
      if (rx_hold_left != 0) begin
        rsp_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   rsp_ready <= 1'b1;
          RX_COIN:   rsp_ready <= $urandom_range(0, 1);
          RX_MOSTLY: rsp_ready <= ($urandom_range(0, 99) < 85);
          default:   rsp_ready <= (cycle_count % 5 != 0);
        endcase
      end
    end
  end

  // Response monitor: compare against the oldest expectation
  rsp_item_t rsp_want;
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (rsp_expect_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected response, expected none, got %p", $time, rsp_item);
      end else begin
        rsp_want = rsp_expect_q.pop_front();
        check_field("status", rsp_want.status, rsp_item.status);
        check_field("run_valid", rsp_want.run_valid, rsp_item.run_valid);
        check_field("run_task_id", rsp_want.run_task_id, rsp_item.run_task_id);
        check_field("pending_count", rsp_want.pending_count, rsp_item.pending_count);
      end
    end
  end

  // Cycle limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t ns: timeout after %0d cycles, %0d responses outstanding",
             $time, cycle_count, rsp_expect_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus
  initial begin
    int   random_left;
    int   round_len;
    mix_t mix;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty list: tick and dispatch do nothing; the unused code is ignored
    push_cmd(CMD_TICK, 8'h00, 16'h0000, 16'h0000);
    push_cmd(CMD_DISPATCH, 8'hFF, 16'hFFFF, 16'hFFFF);
    push_cmd(CMD_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF);
    // Due now: not ready before a tick, stays ready over a second tick
    push_cmd(CMD_ADD, 8'hFF, 16'h0000, 16'h0000);
    push_cmd(CMD_DISPATCH, 8'h00, 16'h0000, 16'h0000);
    push_cmd(CMD_TICK, 8'h00, 16'h0000, 16'h0000);
    push_cmd(CMD_TICK, 8'h00, 16'h0000, 16'h0000);
    push_cmd(CMD_DISPATCH, 8'h00, 16'h0000, 16'h0000);
    // Equal due time goes behind; an earlier task goes in front of the head
    push_cmd(CMD_ADD, 8'h00, 16'd2, 16'h0000);
    push_cmd(CMD_ADD, 8'h01, 16'd2, 16'h0000);
    push_cmd(CMD_ADD, 8'h02, 16'd1, 16'h0000);
    push_cmd(CMD_TICK, 8'h00, 16'h0000, 16'h0000);
    push_cmd(CMD_TICK, 8'h00, 16'h0000, 16'h0000);
    push_cmd(CMD_DISPATCH, 8'h00, 16'h0000, 16'h0000);
    push_cmd(CMD_TICK, 8'h00, 16'h0000, 16'h0000);
    push_cmd(CMD_TICK, 8'h00, 16'h0000, 16'h0000);
    push_cmd(CMD_DISPATCH, 8'h00, 16'h0000, 16'h0000);
    // Follower with zero delta needs its own tick before it can run
    push_cmd(CMD_DISPATCH, 8'h00, 16'h0000, 16'h0000);
    push_cmd(CMD_TICK, 8'h00, 16'h0000, 16'h0000);
    push_cmd(CMD_DISPATCH, 8'h00, 16'h0000, 16'h0000);
    // Periodic re-insert at the longest period, then a far one-shot
    push_cmd(CMD_ADD, 8'hA5, 16'h0000, 16'hFFFF);
    push_cmd(CMD_TICK, 8'h00, 16'h0000, 16'h0000);
    push_cmd(CMD_DISPATCH, 8'h00, 16'h0000, 16'h0000);
    push_cmd(CMD_ADD, 8'h5A, 16'hFFFF, 16'h0000);
    push_cmd(CMD_ADD, 8'h3C, 16'd3, 16'd3);
    wait_idle();

    // Random rounds; now and then let everything drain before going on
    random_left = RANDOM_ITEMS;
    while (random_left > 0) begin
      mix       = mix_t'($urandom_range(0, 2));
      round_len = $urandom_range(30, 80);
      if (round_len > random_left) round_len = random_left;
      repeat (round_len) queue_random_item(mix);
      random_left -= round_len;
      if ($urandom_range(0, 3) == 0) wait_idle();
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (rsp_expect_q.size() != 0) begin
      mismatches++;
      $display("%0t ns: responses missing, expected %0d more, got 0",
               $time, rsp_expect_q.size());
    end
    $display("Ran %0d commands in %0d cycles, list depth peaked at %0d of %0d.",
             items_accepted, cycle_count, peak_count, MAX_TASKS);
    $display("Tasks handed out %0d, adds refused when full %0d, dispatches with none ready %0d.",
             runs_handed, adds_refused, empty_dispatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[delta_list_task_scheduler_top.f]
design/dls_pkg.sv
design/dls_ram.sv
design/dls_alu.sv
design/dls_seq.sv
design/delta_list_task_scheduler_top.sv
tb/delta_list_task_scheduler_top_test.sv
